>>> src/dring_pkg.sv
// ----------------------------------------------------------------------------
// dring_pkg
// Shared types, constants and slot arithmetic for the double-ended ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dring_pkg;

    // Queue geometry.
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W      = SLOT_W + 6;

    // Field widths of one word on either side.
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int OFFSET_W = 4;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_PEEK_HEAD = 3'd4,
        OP_PEEK_TAIL = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Store access requested by the control logic for one word.
    typedef struct packed {
        logic                  wr_en;
        logic [SLOT_W-1:0]     wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
        logic [SLOT_W-1:0]     rd_addr;
    } store_req_t;

    // One result word.
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

    // Next slot toward the tail, wrapping at the capacity.
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    // Next slot toward the head, wrapping at zero.
    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == '0) begin
            r = SLOT_W'(CAPACITY - 1);
        end else begin
            r = s - SLOT_W'(1);
        end
        return r;
    endfunction

    // Reduce a sum known to be below twice the capacity to a slot.
    function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] r;
        if (v >= SUM_W'(CAPACITY)) begin
            r = v - SUM_W'(CAPACITY);
        end else begin
            r = v;
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/dring_store.sv
// ----------------------------------------------------------------------------
// dring_store
// Ring store of the queue: one write port and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dring_store
    import dring_pkg::*;
(
    input  wire logic                  clk,
    input  wire store_req_t            req,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] entry_reg [CAPACITY];

    // Write one entry per word; the contents have no reset value.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entry_reg[req.wr_addr] <= req.wr_data;
        end
    end

    // The entry read for a pop or a peek.
    assign rd_data = entry_reg[req.rd_addr];

endmodule

`default_nettype wire

>>> src/dring_ctrl.sv
// ----------------------------------------------------------------------------
// dring_ctrl
// Operation decode, head and tail slots, fill count and result forming.
// ----------------------------------------------------------------------------
`default_nettype none

module dring_ctrl
    import dring_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire logic [OP_W-1:0]       op,
    input  wire logic [VALUE_W-1:0]    value,
    input  wire logic [OFFSET_W-1:0]   offset,
    input  wire logic [DATA_WIDTH-1:0] rd_data,
    output store_req_t                 req,
    output result_t                    result
);

    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [SLOT_W-1:0]  tail_reg, tail_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               full;
    logic               empty;
    logic               in_range;
    logic [SUM_W-1:0]   head_sum;
    logic [SUM_W-1:0]   tail_sum;
    logic               take_read;
    status_t            status;

    assign full     = (count_reg >= COUNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign in_range = (COUNT_W'(offset) < count_reg);

    // Peek slots: the offset is below the count, so one wrap is enough.
    assign head_sum = SUM_W'(head_reg) + SUM_W'(1) + SUM_W'(offset);
    assign tail_sum = SUM_W'(tail_reg) + SUM_W'(CAPACITY) - SUM_W'(offset) - SUM_W'(1);

    // Decode the operation and work out the next slots and count.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status      = ST_OK;
        take_read   = 1'b0;
        req.wr_en   = 1'b0;
        req.wr_addr = head_reg;
        req.wr_data = value[DATA_WIDTH-1:0];
        req.rd_addr = head_reg;
        case (op_t'(op))
            OP_PUSH_HEAD:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    req.wr_en   = fire;
                    req.wr_addr = head_reg;
                    head_next   = slot_dec(head_reg);
                    count_next  = count_reg + COUNT_W'(1);
                end
            end
            OP_PUSH_TAIL:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    req.wr_en   = fire;
                    req.wr_addr = tail_reg;
                    tail_next   = slot_inc(tail_reg);
                    count_next  = count_reg + COUNT_W'(1);
                end
            end
            OP_POP_HEAD:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    head_next   = slot_inc(head_reg);
                    req.rd_addr = head_next;
                    take_read   = 1'b1;
                    count_next  = count_reg - COUNT_W'(1);
                end
            end
            OP_POP_TAIL:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    tail_next   = slot_dec(tail_reg);
                    req.rd_addr = tail_next;
                    take_read   = 1'b1;
                    count_next  = count_reg - COUNT_W'(1);
                end
            end
            OP_PEEK_HEAD:
            begin
                if (!in_range)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    req.rd_addr = slot_wrap(head_sum);
                    take_read   = 1'b1;
                end
            end
            OP_PEEK_TAIL:
            begin
                if (!in_range)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    req.rd_addr = slot_wrap(tail_sum);
                    take_read   = 1'b1;
                end
            end
            default:
            begin
                // Unused codes leave everything as it is.
            end
        endcase
    end

    // Result word: the element only on a successful pop or peek.
    always_comb
    begin
        result.status = status;
        result.value  = take_read ? VALUE_W'(rd_data) : '0;
        result.count  = CNT_W'(count_next);
    end

    // Slot and count registers advance once per processed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= SLOT_W'(1 % CAPACITY);
            count_reg <= '0;
        end
        else if (fire)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // The fill count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // The tail slot always sits count plus one slots past the head slot.
    a_ring_gap: assert property (@(posedge clk) disable iff (!rst_n)
        ((32'(head_reg) + 32'(count_reg) + 32'd1) % CAPACITY) == 32'(tail_reg))
        else $error("head, tail and fill count disagree");

    // The count only changes when a word is processed.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(count_reg))
        else $error("fill count changed without a word");

endmodule

`default_nettype wire

>>> src/double_ended_ring_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_ring_queue_core
// Fixed-capacity double-ended queue with push, pop and peek at both ends.
// ----------------------------------------------------------------------------
// Each accepted word carries one operation and gives exactly one result word
// with a status, the element read and the fill count after the operation. A
// word is captured in an input register and processed once the output
// register is free or being drained, against the head slot, tail slot, fill
// count and the register-based ring store; the result lands in an output
// register. The block sustains one word per clock cycle while the result side
// keeps accepting. While a result word waits on the result side, the next
// request word is held in the input register and the request side stalls.
// The ring store has no reset and no clearing pass: an entry is only read
// after it has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_ring_queue_core
    import dring_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request side.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value[31:0], offset[35:32], zero pad
    input  wire logic [2:0]  s_tuser,   // op[2:0]
    // Result side.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // status[1:0], value_out[33:2], count[38:34], pad
);

    logic                  in_valid_reg;
    logic [OP_W-1:0]       op_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic                  out_valid_reg;
    result_t               result_reg;

    logic                  fire;
    store_req_t            req;
    result_t               result;
    logic [DATA_WIDTH-1:0] rd_data;

    // A word is processed when the output register is free or being drained.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, result_reg};

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg     <= s_tuser[OP_W-1:0];
            value_reg  <= s_tdata[VALUE_W-1:0];
            offset_reg <= s_tdata[VALUE_W +: OFFSET_W];
        end
    end

    // Control and ring store.
    dring_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .op      (op_reg),
        .value   (value_reg),
        .offset  (offset_reg),
        .rd_data (rd_data),
        .req     (req),
        .result  (result)
    );

    dring_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    // The request side only stalls behind a blocked result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("request side stalled without a blocked result");

    // A result that is not ok carries no element.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.status != ST_OK) |-> (result_reg.value == '0))
        else $error("error result carries an element");

    // A processed word always shows up as a result in the next cycle.
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed word produced no result");

endmodule

`default_nettype wire

>>> sim/double_ended_ring_queue_core_tb.sv
// ----------------------------------------------------------------------------
// double_ended_ring_queue_core_tb
// Self-checking testbench for the double-ended ring queue core.
// ----------------------------------------------------------------------------
// A shadow deque inside the testbench tracks the head slot, tail slot, fill
// count and ring contents. It computes the status, element and count for every
// accepted request word. A checker compares each result word with the oldest
// prediction. Directed tests cover the empty and full corners, the unused
// opcodes and the peek distance extremes. A backpressure test holds the result
// side off until the core stalls its input. The random traffic test then walks
// the fill level up and down across the whole capacity.
// ----------------------------------------------------------------------------

module double_ended_ring_queue_core_tb;
    import dring_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes the core must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        status_t      status;
        logic [31:0]  value;
        logic [4:0]   count;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // value[31:0], offset[35:32], zero pad
    logic [2:0]  s_tuser = '0;     // op[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // status[1:0], value_out[33:2], count[38:34], pad

    // Shadow copy of the queue state.
    logic [DATA_WIDTH-1:0] shadow_ring [CAPACITY];
    int                    shadow_head;
    int                    shadow_tail;
    int                    shadow_fill;

    outcome_t pending_results [$];
    int       mismatch_count = 0;

    // Idle controls shared between the stimulus and the result-side process.
    bit src_gaps  = 1'b1;
    bit sink_gaps = 1'b1;
    bit sink_hold = 1'b0;

    double_ended_ring_queue_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #10_000_000;
        $display("double_ended_ring_queue_core_tb: done, errors");
        $finish;
    end

    // Update the shadow deque for one accepted word and queue its result.
    task automatic predict_deque_op(input logic [2:0] op, input logic [31:0] value,
                                    input logic [3:0] offset);
        outcome_t res;
        int       slot;
        res.status = ST_OK;
        res.value  = '0;
        case (op)
            OP_PUSH_HEAD:
            begin
                if (shadow_fill >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_ring[shadow_head] = value;
                    shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
                    shadow_fill++;
                end
            end
            OP_PUSH_TAIL:
            begin
                if (shadow_fill >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_ring[shadow_tail] = value;
                    shadow_tail = (shadow_tail + 1) % CAPACITY;
                    shadow_fill++;
                end
            end
            OP_POP_HEAD:
            begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_head = (shadow_head + 1) % CAPACITY;
                    shadow_fill--;
                    res.value = shadow_ring[shadow_head];
                end
            end
            OP_POP_TAIL:
            begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_tail = (shadow_tail + CAPACITY - 1) % CAPACITY;
                    shadow_fill--;
                    res.value = shadow_ring[shadow_tail];
                end
            end
            OP_PEEK_HEAD:
            begin
                if (int'(offset) >= shadow_fill) begin
                    res.status = ST_RANGE;
                end else begin
                    slot = (shadow_head + 1 + int'(offset)) % CAPACITY;
                    res.value = shadow_ring[slot];
                end
            end
            OP_PEEK_TAIL:
            begin
                if (int'(offset) >= shadow_fill) begin
                    res.status = ST_RANGE;
                end else begin
                    slot = (shadow_tail + CAPACITY - ((1 + int'(offset)) % CAPACITY))
                           % CAPACITY;
                    res.value = shadow_ring[slot];
                end
            end
            default:
            begin
                // Unused opcodes leave the state alone.
            end
        endcase
        res.count = 5'(shadow_fill);
        pending_results.push_back(res);
    endtask

    // Offer one request word and wait until it is taken. Called and returns
    // at a falling edge; tvalid stays high so back-to-back words need no gap.
    task automatic send_word(input logic [2:0] op, input logic [31:0] value,
                             input logic [3:0] offset);
        int gap;
        gap = src_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, offset, value};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_deque_op(op, value, offset);
        @(negedge clk);
    endtask

    // Hold the request side idle until every predicted result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    // Draw one random request word. grow favors pushes over pops.
    task automatic pick_word(input bit grow, output logic [2:0] op,
                             output logic [31:0] value, output logic [3:0] offset);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            op = r[0] ? OP_UNUSED_A : OP_UNUSED_B;
        end else if (r < 22) begin
            op = r[0] ? OP_PEEK_HEAD : OP_PEEK_TAIL;
        end else if ($urandom_range(0, 99) < (grow ? 75 : 25)) begin
            op = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        end else begin
            op = $urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL;
        end
        // Peek distances mostly land inside the queue.
        if (shadow_fill > 0 && $urandom_range(0, 3) != 0) begin
            offset = 4'($urandom_range(0, shadow_fill - 1));
        end else begin
            offset = 4'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 15))
            0:       value = 32'h0000_0000;
            1:       value = 32'hFFFF_FFFF;
            default: value = $urandom;
        endcase
    endtask

    // Pops and peeks on an empty queue, plus the unused opcodes.
    task automatic test_empty_corners();
        send_word(OP_POP_HEAD, 32'h1234_5678, 4'h0);
        send_word(OP_POP_TAIL, 32'h8765_4321, 4'h0);
        send_word(OP_PEEK_HEAD, 32'h0, 4'h0);
        send_word(OP_PEEK_TAIL, 32'h0, 4'h0);
        send_word(OP_UNUSED_A, 32'hFFFF_FFFF, 4'hF);
        send_word(OP_UNUSED_B, 32'hFFFF_FFFF, 4'hF);
        drain_results();
    endtask

    // Fill from both ends, push into a full queue, peek at the far ends.
    task automatic test_fill_to_full();
        logic [31:0] value;
        for (int i = 0; i < CAPACITY; i++) begin
            case (i)
                0:       value = 32'h0000_0000;
                1:       value = 32'hFFFF_FFFF;
                2:       value = 32'h8000_0000;
                3:       value = 32'h0000_0001;
                default: value = $urandom;
            endcase
            send_word(i[0] ? OP_PUSH_TAIL : OP_PUSH_HEAD, value, 4'(i));
        end
        send_word(OP_PUSH_HEAD, 32'hDEAD_BEEF, 4'h0);
        send_word(OP_PUSH_TAIL, 32'hCAFE_F00D, 4'h0);
        send_word(OP_PEEK_HEAD, 32'h0, 4'hF);
        send_word(OP_PEEK_TAIL, 32'h0, 4'hF);
        drain_results();
    endtask

    // Keep offering words while the result side is held off for a long time.
    task automatic test_backpressure();
        logic [2:0]  op;
        logic [31:0] value;
        logic [3:0]  offset;
        src_gaps = 1'b0;
        fork
            begin
                sink_hold = 1'b1;
                repeat (80) @(posedge clk);
                sink_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 48; i++) begin
                    pick_word(shadow_fill < CAPACITY / 2, op, value, offset);
                    send_word(op, value, offset);
                end
            end
        join
        src_gaps = 1'b1;
        drain_results();
    endtask

    // Long random run that sweeps the fill level between empty and full.
    task automatic test_random_traffic(input int n_items);
        logic [2:0]  op;
        logic [31:0] value;
        logic [3:0]  offset;
        int          done_items;
        int          iter;
        bit          grow;
        done_items = 0;
        iter       = 0;
        grow       = 1'b1;
        while (done_items < n_items) begin
            // Switch idling on and off in stretches on both sides.
            if (iter % 97 == 0) begin
                src_gaps  = ($urandom_range(0, 2) != 0);
                sink_gaps = ($urandom_range(0, 2) != 0);
            end
            if (shadow_fill == CAPACITY) begin
                grow = 1'b0;
            end else if (shadow_fill == 0) begin
                grow = 1'b1;
            end else if ($urandom_range(0, 39) == 0) begin
                grow = ~grow;
            end
            pick_word(grow, op, value, offset);
            send_word(op, value, offset);
            if (op != OP_UNUSED_A && op != OP_UNUSED_B) begin
                done_items++;
            end
            iter++;
        end
        drain_results();
    endtask

    // Result side: random stall before each word, long hold when requested.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = sink_gaps ? $urandom_range(0, 7) : 0;
            if (stall > 0 || sink_hold) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
                while (sink_hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Compare each result word with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        outcome_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = status_t'(m_tdata[1:0]);
            got.value  = m_tdata[33:2];
            got.count  = m_tdata[38:34];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN) begin
                    $display("%0t: unexpected result word status=%0d value=%h count=%0d",
                             $realtime, got.status, got.value, got.count);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN) begin
                        $display("%0t: mismatch status exp=%0d got=%0d value exp=%h got=%h count exp=%0d got=%0d",
                                 $realtime, want.status, got.status, want.value, got.value,
                                 want.count, got.count);
                    end
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        shadow_head = 0;
        shadow_tail = 1 % CAPACITY;
        shadow_fill = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_corners();
        test_fill_to_full();
        test_backpressure();
        test_random_traffic(1450);

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("double_ended_ring_queue_core_tb: done, clean");
        end else begin
            $display("double_ended_ring_queue_core_tb: done, errors");
        end
        $finish;
    end

endmodule
